### rtl/core/afrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afrp_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned ProdW = 2 * ChanW;
  localparam int unsigned PackW = 16;

  localparam logic [ChanW-1:0] AlphaOpaque = 8'hFF;

  localparam logic [1:0] RegForceOpaque = 2'd0;
  localparam logic [1:0] RegBackground  = 2'd1;
  localparam logic [1:0] RegPackEnable  = 2'd2;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] alpha;
  } pix_t;

  typedef struct packed {
    logic             force_opaque;
    logic [23:0]      background_color;
    logic             pack_enable;
  } cfg_t;

  // floor(s / 255), exact for every s up to 255 * 255
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] s);
    logic [ProdW:0] t;
    t = {1'b0, s} + {{ProdW{1'b0}}, 1'b1} + {{(ChanW+1){1'b0}}, s[ProdW-1:ChanW]};
    return t[ProdW-1:ChanW];
  endfunction

endpackage

`default_nettype wire

### rtl/core/afrp_blend_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module afrp_blend_pipe
  import afrp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire pix_t             in_pix_i,
  input  wire logic             in_last_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output pix_t                  out_pix_o,
  output logic [PackW-1:0]      out_packed_o,
  output logic                  out_last_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  pix_t             pix1_q, pix2_q;
  logic             last1_q, last2_q;
  logic [ProdW-1:0] pc1_q [3];
  logic [ProdW-1:0] pb1_q [3];
  logic [ProdW-1:0] sum2_q [3];

  pix_t             pix3_q;
  logic [PackW-1:0] packed3_q;
  logic             last3_q;

  logic [ChanW-1:0] bg [3];
  logic [ChanW-1:0] src [3];
  logic [ChanW-1:0] inv_a;
  logic [ChanW-1:0] blend [3];
  pix_t             res_d;
  logic [PackW-1:0] packed_d;

  assign rdy3 = !v3_q || !out_stall_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  assign bg[0]  = cfg_i.background_color[7:0];
  assign bg[1]  = cfg_i.background_color[15:8];
  assign bg[2]  = cfg_i.background_color[23:16];
  assign src[0] = in_pix_i.blue;
  assign src[1] = in_pix_i.green;
  assign src[2] = in_pix_i.red;
  assign inv_a  = ~in_pix_i.alpha;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // multiply
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      pix1_q  <= in_pix_i;
      last1_q <= in_last_i;
      for (int i = 0; i < 3; i++) begin
        pc1_q[i] <= {{ChanW{1'b0}}, src[i]} * {{ChanW{1'b0}}, in_pix_i.alpha};
        pb1_q[i] <= {{ChanW{1'b0}}, bg[i]} * {{ChanW{1'b0}}, inv_a};
      end
    end
  end

  // accumulate
  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      pix2_q  <= pix1_q;
      last2_q <= last1_q;
      for (int i = 0; i < 3; i++) begin
        sum2_q[i] <= pc1_q[i] + pb1_q[i];
      end
    end
  end

  // divide, select, pack
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      blend[i] = div255(sum2_q[i]);
    end
    res_d = pix2_q;
    if (cfg_i.force_opaque) begin
      res_d.blue  = blend[0];
      res_d.green = blend[1];
      res_d.red   = blend[2];
      res_d.alpha = AlphaOpaque;
    end
    packed_d = '0;
    if (cfg_i.pack_enable) begin
      packed_d = {res_d.red[7:3], res_d.green[7:2], res_d.blue[7:3]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      pix3_q    <= res_d;
      packed3_q <= packed_d;
      last3_q   <= last2_q;
    end
  end

  assign out_valid_o  = v3_q;
  assign out_pix_o    = pix3_q;
  assign out_packed_o = packed3_q;
  assign out_last_o   = last3_q;

endmodule

`default_nettype wire

### rtl/core/alpha_flatten_rgb565_pack.sv
// channel   direction  handshake              payload
// pixel in  in         in_valid_i / in_stall_o pix_blue/green/red/alpha, frame_last
// result    out        out_valid_o / stall_i   res_blue/green/red/alpha, res_packed, res_last
// config    in         APB psel/penable/pready force_opaque, background_color, pack_enable
//
// One pixel per cycle while stall_i is low, through multiply, add and divide stages.
// Asynchronous active-low reset clears the stage valid bits and the config registers.
// A stalled result holds the last stage; earlier stages fill any bubbles first.
// in_stall_o rises only while all three stages hold data and stall_i is high.
`timescale 1ns / 1ps
`default_nettype none

module alpha_flatten_rgb565_pack
  import afrp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  pix_blue_i,
  input  wire logic [7:0]  pix_green_i,
  input  wire logic [7:0]  pix_red_i,
  input  wire logic [7:0]  pix_alpha_i,
  input  wire logic        frame_last_i,
  output logic             out_valid_o,
  input  wire logic        stall_i,
  output logic [7:0]       res_blue_o,
  output logic [7:0]       res_green_o,
  output logic [7:0]       res_red_o,
  output logic [7:0]       res_alpha_o,
  output logic [15:0]      res_packed_o,
  output logic             res_last_o
);

  cfg_t cfg_q;
  pix_t in_pix;
  pix_t out_pix;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegForceOpaque: cfg_q.force_opaque     <= pwdata[0];
        RegBackground:  cfg_q.background_color <= pwdata[23:0];
        RegPackEnable:  cfg_q.pack_enable      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegForceOpaque: prdata = {31'd0, cfg_q.force_opaque};
      RegBackground:  prdata = {8'd0, cfg_q.background_color};
      RegPackEnable:  prdata = {31'd0, cfg_q.pack_enable};
      default:        prdata = '0;
    endcase
  end

  assign in_pix.blue  = pix_blue_i;
  assign in_pix.green = pix_green_i;
  assign in_pix.red   = pix_red_i;
  assign in_pix.alpha = pix_alpha_i;

  afrp_blend_pipe u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_pix_i     (in_pix),
    .in_last_i    (frame_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (stall_i),
    .out_pix_o    (out_pix),
    .out_packed_o (res_packed_o),
    .out_last_o   (res_last_o)
  );

  assign res_blue_o  = out_pix.blue;
  assign res_green_o = out_pix.green;
  assign res_red_o   = out_pix.red;
  assign res_alpha_o = out_pix.alpha;

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && stall_i))
    else $error("input stalled while output not blocked");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !stall_i ##1 !stall_i |=> out_valid_o)
    else $error("accepted pixel failed to reach output");

endmodule

`default_nettype wire
